FILE: hdl/sfr_pkg.sv
// Shared types, codes and reset values for the serial frame receiver.
package sfr_pkg;

	// Byte and configuration index widths
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_CODE       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_CTRL_CODE  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_START_CODE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_END_CODE   = 4'd3;

	// Configuration reset values
	localparam logic [BYTE_W-1:0] RST_SYNC_CODE       = 8'd22;
	localparam logic [BYTE_W-1:0] RST_DATA_CTRL_CODE  = 8'd2;
	localparam logic [BYTE_W-1:0] RST_FILE_START_CODE = 8'd35;
	localparam logic [BYTE_W-1:0] RST_FILE_END_CODE   = 8'd64;

	// Event kinds on the result channel
	typedef enum logic [2:0] {
		KIND_PLAIN  = 3'd0,
		KIND_FSTART = 3'd1,
		KIND_FEND   = 3'd2,
		KIND_CTRL   = 3'd3,
		KIND_DATA   = 3'd4,
		KIND_DEND   = 3'd5
	} kind_t;

	// Frame field being expected next
	typedef enum logic [2:0] {
		FLD_SYNC  = 3'd1,
		FLD_ADDR  = 3'd2,
		FLD_CTRL  = 3'd3,
		FLD_NUM   = 3'd4,
		FLD_LEN   = 3'd5,
		FLD_DATA  = 3'd6,
		FLD_CHECK = 3'd7
	} fld_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_code;
		logic [BYTE_W-1:0] data_control_code;
		logic [BYTE_W-1:0] file_start_code;
		logic [BYTE_W-1:0] file_end_code;
	} cfg_t;

	typedef struct packed {
		fld_t              field_index;
		logic              in_frame;
		logic              is_data_frame;
		logic              file_mode;
		logic [BYTE_W-1:0] data_count;
		logic [BYTE_W-1:0] length;
		logic [BYTE_W-1:0] address;
		logic [BYTE_W-1:0] control;
		logic [BYTE_W-1:0] number;
	} state_t;

	typedef struct packed {
		kind_t             event_kind;
		logic [BYTE_W-1:0] char_value;
		logic              to_file;
		logic [BYTE_W-1:0] frame_address;
		logic [BYTE_W-1:0] frame_control;
		logic [BYTE_W-1:0] frame_number;
		logic [BYTE_W-1:0] frame_length;
		logic [BYTE_W-1:0] check_byte;
	} result_t;

	localparam state_t STATE_RESET = '{
		field_index:   FLD_SYNC,
		in_frame:      1'b0,
		is_data_frame: 1'b0,
		file_mode:     1'b0,
		data_count:    '0,
		length:        '0,
		address:       '0,
		control:       '0,
		number:        '0
	};

endpackage

FILE: hdl/sfr_if.sv
// Channel interfaces: received byte, result event and configuration write.
interface sfr_byte_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_event_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [2:0]        event_kind;
	logic [BYTE_W-1:0] char_value;
	logic              to_file;
	logic [BYTE_W-1:0] frame_address;
	logic [BYTE_W-1:0] frame_control;
	logic [BYTE_W-1:0] frame_number;
	logic [BYTE_W-1:0] frame_length;
	logic [BYTE_W-1:0] check_byte;

	modport source (output valid, output event_kind, output char_value, output to_file,
		output frame_address, output frame_control, output frame_number,
		output frame_length, output check_byte, input ready);
	modport sink   (input valid, input event_kind, input char_value, input to_file,
		input frame_address, input frame_control, input frame_number,
		input frame_length, input check_byte, output ready);
endinterface

interface sfr_cfg_if import sfr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [BYTE_W-1:0]    wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hdl/sfr_decode.sv
// Per-byte decoder: next receiver state and the optional result event.
module sfr_decode import sfr_pkg::*; (
	input  cfg_t              cfg,
	input  state_t            st,
	input  logic [BYTE_W-1:0] rx_byte,
	output state_t            st_next,
	output logic              emit,
	output result_t           res
);

	logic [BYTE_W-1:0] count_inc;

	assign count_inc = st.data_count + 1'b1;

	always_comb begin
		st_next = st;
		emit    = 1'b0;
		res     = '0;

		if (!st.in_frame && rx_byte != cfg.sync_code) begin
			// Outside a frame: file mode toggles or plain character
			emit = 1'b1;
			if (!st.file_mode && rx_byte == cfg.file_start_code) begin
				st_next.file_mode = 1'b1;
				res.event_kind    = KIND_FSTART;
			end else if (st.file_mode && rx_byte == cfg.file_end_code) begin
				st_next.file_mode = 1'b0;
				res.event_kind    = KIND_FEND;
			end else begin
				res.event_kind = KIND_PLAIN;
				res.char_value = rx_byte;
			end
		end else begin
			// Frame fields
			case (st.field_index)
				FLD_ADDR: begin
					st_next.address     = rx_byte;
					st_next.field_index = FLD_CTRL;
				end
				FLD_CTRL: begin
					st_next.control = rx_byte;
					if (rx_byte == cfg.data_control_code)
						st_next.is_data_frame = 1'b1;
					st_next.field_index = FLD_NUM;
				end
				FLD_NUM: begin
					st_next.number = rx_byte;
					if (!st.is_data_frame) begin
						emit                  = 1'b1;
						res.event_kind        = KIND_CTRL;
						res.frame_address     = st.address;
						res.frame_control     = st.control;
						res.frame_number      = rx_byte;
						st_next.field_index   = FLD_SYNC;
						st_next.in_frame      = 1'b0;
						st_next.is_data_frame = 1'b0;
					end else begin
						st_next.field_index = FLD_LEN;
					end
				end
				FLD_LEN: begin
					st_next.length      = rx_byte;
					st_next.data_count  = '0;
					st_next.field_index = (rx_byte == '0) ? FLD_CHECK : FLD_DATA;
				end
				FLD_DATA: begin
					emit              = 1'b1;
					res.event_kind    = KIND_DATA;
					res.char_value    = rx_byte;
					res.to_file       = st.file_mode;
					res.frame_address = st.address;
					res.frame_control = st.control;
					res.frame_number  = st.number;
					res.frame_length  = st.length;
					if (count_inc == st.length) begin
						st_next.data_count  = '0;
						st_next.field_index = FLD_CHECK;
					end else begin
						st_next.data_count = count_inc;
					end
				end
				FLD_CHECK: begin
					emit                  = 1'b1;
					res.event_kind        = KIND_DEND;
					res.to_file           = st.file_mode;
					res.frame_address     = st.address;
					res.frame_control     = st.control;
					res.frame_number      = st.number;
					res.frame_length      = st.length;
					res.check_byte        = rx_byte;
					st_next.field_index   = FLD_SYNC;
					st_next.in_frame      = 1'b0;
					st_next.is_data_frame = 1'b0;
				end
				default: begin
					// Expecting sync
					if (rx_byte == cfg.sync_code) begin
						st_next.in_frame      = 1'b1;
						st_next.is_data_frame = 1'b0;
						st_next.field_index   = FLD_ADDR;
					end else begin
						st_next.field_index   = FLD_SYNC;
						st_next.in_frame      = 1'b0;
						st_next.is_data_frame = 1'b0;
					end
				end
			endcase
		end
	end

endmodule

FILE: hdl/serial_frame_receiver_unit.sv
// Top level of the sync-byte framed serial receiver.
//
//  channel  dir  signals                                   request
//  rx       in   valid ready rx_byte                       one received byte
//  ev       out  valid ready event_kind char_value ...     one result event
//  cfg      in   valid ready reg_index wr_data             one register write
//
// Each byte is decoded in the cycle it is accepted; the state registers and
// the result register load at that edge, so one byte per cycle is sustained
// while rx.ready is high; a result shows in the cycle after its byte. Sync,
// address, control, number (data frame) and length bytes give no result.
// rx.ready drops only while a result is held in the register and ev.ready is
// low. cfg.ready is always high. Reset sets the frame state to expecting sync
// and the codes to their defaults; no clearing pass is needed.
module serial_frame_receiver_unit import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sfr_byte_if.sink    rx,
	sfr_event_if.source ev,
	sfr_cfg_if.sink     cfg
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	logic    emit;
	result_t res;
	result_t res_q;
	logic    ev_valid_q;
	logic    rx_take;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_code         <= RST_SYNC_CODE;
			cfg_q.data_control_code <= RST_DATA_CTRL_CODE;
			cfg_q.file_start_code   <= RST_FILE_START_CODE;
			cfg_q.file_end_code     <= RST_FILE_END_CODE;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_SYNC_CODE:       cfg_q.sync_code         <= cfg.wr_data;
				CFG_DATA_CTRL_CODE:  cfg_q.data_control_code <= cfg.wr_data;
				CFG_FILE_START_CODE: cfg_q.file_start_code   <= cfg.wr_data;
				CFG_FILE_END_CODE:   cfg_q.file_end_code     <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Byte decoder
	sfr_decode u_decode (
		.cfg     (cfg_q),
		.st      (st_q),
		.rx_byte (rx.rx_byte),
		.st_next (st_next),
		.emit    (emit),
		.res     (res)
	);

	// Accept while the result register is empty or being drained
	assign rx.ready = !ev_valid_q || ev.ready;
	assign rx_take  = rx.valid && rx.ready;

	// Receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (rx_take) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (rx_take) begin
			ev_valid_q <= emit;
		end else if (ev.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && emit)
			res_q <= res;
	end

	assign ev.valid         = ev_valid_q;
	assign ev.event_kind    = res_q.event_kind;
	assign ev.char_value    = res_q.char_value;
	assign ev.to_file       = res_q.to_file;
	assign ev.frame_address = res_q.frame_address;
	assign ev.frame_control = res_q.frame_control;
	assign ev.frame_number  = res_q.frame_number;
	assign ev.frame_length  = res_q.frame_length;
	assign ev.check_byte    = res_q.check_byte;

	// Frame state consistency
	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.in_frame == (st_q.field_index != FLD_SYNC))
		else $error("in_frame disagrees with field index");

	a_data_flag: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.is_data_frame |-> st_q.in_frame)
		else $error("data frame flag set outside a frame");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.field_index == FLD_DATA) |-> (st_q.data_count < st_q.length))
		else $error("data count reached length in data phase");

	a_file_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.file_mode != $past(st_q.file_mode)) |->
		(ev_valid_q && (res_q.event_kind == KIND_FSTART || res_q.event_kind == KIND_FEND)))
		else $error("file mode changed without a file event");

endmodule
